@@ rtl/core/pud_pkg.sv @@
// shared types, widths and the factorial table for the permutation unrank decoder
// no dependencies
package pud_pkg;

  localparam int MAX_ELEMENTS_DEF = 6;
  localparam int SLOT_COUNT       = 6;
  localparam int RANK_W           = 10;
  localparam int SIZE_W           = 3;
  localparam int VAL_W            = 3;
  localparam int PROD_W           = 13;

  typedef struct packed {
    logic [RANK_W-1:0]                 rank;
    logic [SIZE_W-1:0]                 size;
    logic [SLOT_COUNT-1:0]             mask;
    logic [SLOT_COUNT-1:0][VAL_W-1:0]  slots;
    logic                              err;
  } pud_item_t;

  // n! for n = 0..6, sizes above six saturate
  function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] n);
    logic [RANK_W-1:0] f;
    unique case (n)
      3'd0:    f = 10'd1;
      3'd1:    f = 10'd1;
      3'd2:    f = 10'd2;
      3'd3:    f = 10'd6;
      3'd4:    f = 10'd24;
      3'd5:    f = 10'd120;
      default: f = 10'd720;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/pud_prep.sv @@
// entry stage: size saturation, range check and free-slot mask setup
// depends on pud_pkg
module pud_prep #(
  parameter int MAX_ELEMENTS = pud_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        valid_in,
  input  logic [pud_pkg::RANK_W-1:0]  rank_in,
  input  logic [pud_pkg::SIZE_W-1:0]  size_in,
  output logic                        valid_r,
  output pud_pkg::pud_item_t          item_r
);
  import pud_pkg::*;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ELEMENTS);

  pud_item_t         item_nxt;
  logic [SIZE_W-1:0] size_sat;
  logic [SLOT_COUNT:0] mask_full;

  always_comb begin
    size_sat  = (size_in > MAX_SIZE) ? MAX_SIZE : size_in;
    mask_full = ((SLOT_COUNT+1)'(1) << size_sat) - (SLOT_COUNT+1)'(1);
    item_nxt.rank  = rank_in;
    item_nxt.size  = size_sat;
    item_nxt.err   = rank_in >= fact(size_sat);
    item_nxt.mask  = item_nxt.err ? '0 : mask_full[SLOT_COUNT-1:0];
    item_nxt.slots = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/core/pud_step.sv @@
// one digit stage: divide by the remaining factorial, pick the free slot, place the step index
// depends on pud_pkg
module pud_step #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                valid_in,
  input  pud_pkg::pud_item_t  item_in,
  output logic                valid_r,
  output pud_pkg::pud_item_t  item_r
);
  import pud_pkg::*;

  localparam logic [SIZE_W-1:0] STEP_VAL = SIZE_W'(STEP);

  pud_item_t         item_nxt;
  logic              active;
  logic [SIZE_W-1:0] rem_pos;
  logic [RANK_W-1:0] f;
  logic [SIZE_W-1:0] q;
  logic [PROD_W-1:0] qf;
  logic [PROD_W-1:0] rank_diff;
  logic [SIZE_W-1:0] k;
  logic [SIZE_W-1:0] pos;
  logic [SIZE_W-1:0] seen;
  logic              found;

  always_comb begin
    item_nxt = item_in;
    active   = !item_in.err && (STEP_VAL < item_in.size);
    rem_pos  = item_in.size - SIZE_W'(1) - STEP_VAL;
    f        = fact(rem_pos);

    // digit is the largest j with j*f not above rank, at most five
    q = '0;
    for (int j = 1; j < SLOT_COUNT; j++) begin
      if ({{(PROD_W-RANK_W){1'b0}}, item_in.rank} >= PROD_W'(f) * PROD_W'(j)) begin
        q = SIZE_W'(j);
      end
    end
    qf        = PROD_W'(f) * PROD_W'(q);
    rank_diff = {{(PROD_W-RANK_W){1'b0}}, item_in.rank} - qf;
    k         = rem_pos - q;

    // k-th set bit of the free mask
    seen  = '0;
    found = 1'b0;
    pos   = '0;
    for (int b = 0; b < SLOT_COUNT; b++) begin
      if (item_in.mask[b] && !found) begin
        if (seen == k) begin
          pos   = SIZE_W'(b);
          found = 1'b1;
        end
        seen = seen + SIZE_W'(1);
      end
    end

    if (active) begin
      item_nxt.rank       = rank_diff[RANK_W-1:0];
      item_nxt.mask       = item_in.mask & ~(SLOT_COUNT'(1) << pos);
      item_nxt.slots[pos] = STEP_VAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/core/permutation_unrank_decoder.sv @@
// top level of the permutation unrank decoder: entry stage and a chain of digit stages
// depends on pud_pkg, pud_prep, pud_step
//
// usage:
//   input channel in_valid / in_stall carries in_rank and in_perm_size (1..6,
//   larger sizes saturate to MAX_ELEMENTS). result channel out_valid / out_stall
//   carries out_slot_0..out_slot_5 and out_rank_error. an item moves on a
//   rising edge with valid high and stall low.
//   the pipeline has one entry stage that checks the rank against size! and
//   builds the free-slot mask, then one stage per digit of the factorial
//   number system, the last one doubling as the output register.
//   throughput is one item per cycle while the result channel is not stalled.
//   a rank at or above size! gives out_rank_error high with all slots zero;
//   slots at or above the size read zero.
//   a synchronous low rst_n empties the pipeline; out_valid is low after it.
//   while out_valid is high and out_stall is high the whole pipeline holds and
//   in_stall goes high, so nothing is dropped or repeated.
module permutation_unrank_decoder #(
  parameter int MAX_ELEMENTS = pud_pkg::MAX_ELEMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_rank,
  input  logic [2:0]  in_perm_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_slot_0,
  output logic [2:0]  out_slot_1,
  output logic [2:0]  out_slot_2,
  output logic [2:0]  out_slot_3,
  output logic [2:0]  out_slot_4,
  output logic [2:0]  out_slot_5,
  output logic        out_rank_error
);
  import pud_pkg::*;

  logic              advance;
  logic [MAX_ELEMENTS:0] stage_valid;
  pud_item_t         stage_item [MAX_ELEMENTS+1];

  // pipeline moves whenever the output register is empty or being taken
  assign advance  = !stage_valid[MAX_ELEMENTS] || !out_stall;
  assign in_stall = !advance;

  pud_prep #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .valid_in (in_valid),
    .rank_in  (in_rank),
    .size_in  (in_perm_size),
    .valid_r  (stage_valid[0]),
    .item_r   (stage_item[0])
  );

  for (genvar s = 0; s < MAX_ELEMENTS; s++) begin : g_step
    pud_step #(
      .STEP(s)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .valid_in (stage_valid[s]),
      .item_in  (stage_item[s]),
      .valid_r  (stage_valid[s+1]),
      .item_r   (stage_item[s+1])
    );
  end

  assign out_valid      = stage_valid[MAX_ELEMENTS];
  assign out_slot_0     = stage_item[MAX_ELEMENTS].slots[0];
  assign out_slot_1     = stage_item[MAX_ELEMENTS].slots[1];
  assign out_slot_2     = stage_item[MAX_ELEMENTS].slots[2];
  assign out_slot_3     = stage_item[MAX_ELEMENTS].slots[3];
  assign out_slot_4     = stage_item[MAX_ELEMENTS].slots[4];
  assign out_slot_5     = stage_item[MAX_ELEMENTS].slots[5];
  assign out_rank_error = stage_item[MAX_ELEMENTS].err;

endmodule

@@ rtl/core/pud_checker.sv @@
// port-level checks for the permutation unrank decoder, bound to the top level
// depends on permutation_unrank_decoder
module pud_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_slot_0,
  input logic [2:0]  out_slot_1,
  input logic [2:0]  out_slot_2,
  input logic [2:0]  out_slot_3,
  input logic [2:0]  out_slot_4,
  input logic [2:0]  out_slot_5,
  input logic        out_rank_error
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a held result keeps the whole pipeline frozen
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result is stalled");

  // an out-of-range rank gives an all-zero permutation
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rank_error |->
      out_slot_0 == 3'd0 && out_slot_1 == 3'd0 && out_slot_2 == 3'd0 &&
      out_slot_3 == 3'd0 && out_slot_4 == 3'd0 && out_slot_5 == 3'd0)
    else $error("nonzero slot on rank error");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable(out_slot_0) && $stable(out_slot_1) && $stable(out_slot_2) &&
      $stable(out_slot_3) && $stable(out_slot_4) && $stable(out_slot_5) &&
      $stable(out_rank_error))
    else $error("stalled result changed");

endmodule

bind permutation_unrank_decoder pud_checker u_pud_checker (.*);
